// ----- rtl/core/md5_sh_pkg.sv -----
package md5_sh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [63:0] digest_head;
    logic [63:0] digest_tail;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_DONE
  } state_e;

  localparam logic [31:0] Iv [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [7:0] PadMark  = 8'h80;
  localparam logic [6:0] LenPos   = 7'd56;
  localparam logic [6:0] BlockEnd = 7'd63;
  localparam logic [5:0] LastRound = 6'd63;

  localparam logic [31:0] RoundAdd [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmt [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a round.
  function automatic logic [3:0] word_index(input logic [5:0] rnd);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
      2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
      2'd3:    idx = 4'(lo * 4'd7);
      default: idx = lo;
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] stage, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (stage)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] wide;
    wide = {x, x} << n;
    return wide[63:32];
  endfunction

  function automatic logic [31:0] byte_swap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ----- rtl/core/md5_stream_hasher_core.sv -----
// Streaming MD5: one message byte per request, 16-byte digest per message.
// A byte request is taken while idle; one that fills a 64-byte block starts a compression
//   (word prefetch, 64 rounds on the shared round unit, chain add); a request with last
//   leads to padding bytes, one or two compressions and a digest load.
// Throughput: one byte request per cycle while idle; no request is taken while busy.
// Reset: async, active low; chain words load the MD5 IV, counters clear, buffer kept.
module md5_stream_hasher_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  md5_sh_pkg::in_req_t   in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output md5_sh_pkg::out_rsp_t  out_rsp_o
);

  // Sequencer state and message bookkeeping.
  md5_sh_pkg::state_e state_q, state_d;
  logic [6:0]  fill_q, fill_d;      // bytes held in the block buffer, 0..64
  logic [63:0] total_q, total_d;    // message bytes, wraps mod 2^64
  logic        pad_q, pad_d;        // message closed, padding in progress
  logic        mark_q, mark_d;      // 0x80 marker written
  logic        len_q, len_d;        // length field being written
  logic [5:0]  round_q, round_d;

  // Chaining words and round working registers.
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a_d, b_d, c_d, d_d;

  // Block buffer: sixteen little-endian words, byte-wide writes.
  logic [31:0] mem_q [16];
  logic [31:0] rd_q;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [7:0]  wr_byte;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  md5_sh_pkg::out_rsp_t out_q;

  logic [63:0] bit_count;
  logic [31:0] round_sum;

  assign bit_count  = {total_q[60:0], 3'b000};
  assign in_ready_o = (state_q == md5_sh_pkg::ST_IDLE);

  // Prefetch the word of the next round while the current one runs.
  assign rd_addr = (state_q == md5_sh_pkg::ST_LOAD) ? md5_sh_pkg::word_index(6'd0)
                                                    : md5_sh_pkg::word_index(round_q + 6'd1);

  // Shared round unit.
  assign round_sum = a_q + md5_sh_pkg::round_f(round_q[5:4], b_q, c_q, d_q)
                     + md5_sh_pkg::RoundAdd[round_q] + rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    total_d     = total_q;
    pad_d       = pad_q;
    mark_d      = mark_q;
    len_d       = len_q;
    round_d     = round_q;
    chain_d     = chain_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    wr_en       = 1'b0;
    wr_byte     = '0;
    out_load    = 1'b0;

    case (state_q)
      md5_sh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          pad_d = in_req_i.last;
          if (in_req_i.has_byte) begin
            wr_en   = 1'b1;
            wr_byte = in_req_i.data_byte;
            fill_d  = fill_q + 7'd1;
            total_d = total_q + 64'd1;
          end
          // A full block compresses first; padding starts afterwards.
          if (in_req_i.has_byte && fill_q == md5_sh_pkg::BlockEnd) begin
            state_d = md5_sh_pkg::ST_LOAD;
          end else if (in_req_i.last) begin
            state_d = md5_sh_pkg::ST_PAD;
          end
        end
      end

      md5_sh_pkg::ST_PAD: begin
        // Write one padding byte per cycle: marker, zeros, then bit count.
        wr_en  = 1'b1;
        fill_d = fill_q + 7'd1;
        if (!mark_q) begin
          wr_byte = md5_sh_pkg::PadMark;
          mark_d  = 1'b1;
        end else if (len_q || fill_q == md5_sh_pkg::LenPos) begin
          wr_byte = bit_count[{fill_q[2:0], 3'b000} +: 8];
          len_d   = 1'b1;
        end else begin
          wr_byte = '0;
        end
        if (fill_q == md5_sh_pkg::BlockEnd) begin
          state_d = md5_sh_pkg::ST_LOAD;
        end
      end

      md5_sh_pkg::ST_LOAD: begin
        a_d     = chain_q[0];
        b_d     = chain_q[1];
        c_d     = chain_q[2];
        d_d     = chain_q[3];
        round_d = '0;
        state_d = md5_sh_pkg::ST_ROUND;
      end

      md5_sh_pkg::ST_ROUND: begin
        a_d     = d_q;
        d_d     = c_q;
        c_d     = b_q;
        b_d     = b_q + md5_sh_pkg::rotl32(round_sum,
                                           md5_sh_pkg::RotAmt[{round_q[5:4], round_q[1:0]}]);
        round_d = round_q + 6'd1;
        if (round_q == md5_sh_pkg::LastRound) begin
          state_d = md5_sh_pkg::ST_FINAL;
        end
      end

      md5_sh_pkg::ST_FINAL: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        fill_d     = '0;
        if (len_q) begin
          state_d = md5_sh_pkg::ST_DONE;
        end else if (pad_q) begin
          state_d = md5_sh_pkg::ST_PAD;
        end else begin
          state_d = md5_sh_pkg::ST_IDLE;
        end
      end

      md5_sh_pkg::ST_DONE: begin
        // Hold until the output register is free, then drop back to the IV.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          chain_d  = md5_sh_pkg::Iv;
          total_d  = '0;
          pad_d    = 1'b0;
          mark_d   = 1'b0;
          len_d    = 1'b0;
          state_d  = md5_sh_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = md5_sh_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= md5_sh_pkg::ST_IDLE;
      fill_q      <= '0;
      total_q     <= '0;
      pad_q       <= 1'b0;
      mark_q      <= 1'b0;
      len_q       <= 1'b0;
      round_q     <= '0;
      chain_q     <= md5_sh_pkg::Iv;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      pad_q       <= pad_d;
      mark_q      <= mark_d;
      len_q       <= len_d;
      round_q     <= round_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Round working registers and digest payload carry no reset.
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    if (out_load) begin
      out_q.digest_head <= {md5_sh_pkg::byte_swap(chain_q[0]),
                            md5_sh_pkg::byte_swap(chain_q[1])};
      out_q.digest_tail <= {md5_sh_pkg::byte_swap(chain_q[2]),
                            md5_sh_pkg::byte_swap(chain_q[3])};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ----- rtl/core/md5_sh_checker.sv -----
module md5_sh_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input md5_sh_pkg::in_req_t   in_req_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input md5_sh_pkg::out_rsp_t  out_rsp_o
);

  // A stalled digest stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("digest dropped while stalled");

  // Closing a message always leaves the block busy with padding or compression.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.last |=> !in_ready_o)
    else $error("ready right after a closing request");

  // A request with neither flag changes nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_req_i.has_byte && !in_req_i.last |=> in_ready_o)
    else $error("empty request made the block busy");

  // A new digest appears only after busy work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("digest appeared without a finishing cycle");

endmodule

bind md5_stream_hasher_core md5_sh_checker u_md5_sh_checker (.*);
